// ----- rtl/sct_pkg.sv -----
// Shared types and constants for the spline curve tessellator.
// Payload structs, controller states, datapath operation codes, saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package sct_pkg;

  localparam int COORD_W = 32;
  localparam int SUB_W   = 8;
  localparam int T_W     = 17;              // t in unsigned Q1.16, 0..65536
  localparam int DIV_W   = SUB_W + 16;      // dividend i*65536 + S/2
  localparam int COEF_W  = COORD_W + 5;     // largest spline coefficient
  localparam int ACC_W   = COORD_W + 8;
  localparam int PROD_W  = COEF_W + T_W + 1;

  localparam logic [1:0] MODE_SPLINE = 2'd0;
  localparam logic [1:0] MODE_LINE   = 2'd1;
  localparam logic [1:0] MODE_POLY   = 2'd2;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_CLOSED  = 2'd1;
  localparam logic [1:0] REG_SUBDIV  = 2'd2;

  localparam logic OPC_LOAD = 1'b0;

  typedef struct packed {
    logic                       opcode;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  qx;
    logic signed [COORD_W-1:0]  qy;
    logic signed [COORD_W-1:0]  qz;
    logic                       no_points;
    logic                       final_sample;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_READ, ST_T2, ST_T3, ST_COEF, ST_MUL1, ST_MUL2,
    ST_MUL3, ST_FINISH, ST_PASS, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV_INIT, OP_DIV_STEP, OP_READ, OP_T2, OP_T3,
    OP_COEF, OP_MUL1, OP_MUL2, OP_MUL3, OP_FIN, OP_PASS
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             latch;
    logic [1:0]       slot;
    logic [1:0]       coord;
    logic             line;
    logic [SUB_W-1:0] sample;
    logic [SUB_W-1:0] divisor;
  } cmd_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] mx;
    logic signed [ACC_W-1:0] mn;
    mx = ACC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    mn = -mx - ACC_W'(1);
    if (v > mx) begin
      return mx[COORD_W-1:0];
    end else if (v < mn) begin
      return mn[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/sct_ctrl.sv -----
// Controller for the spline curve tessellator: state machine, point count,
// curve position, store addressing and sequencing of the datapath.
// Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_ctrl import sct_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     opcode,
  output logic                     busy,
  input  logic                     cfg_clear,
  input  logic [1:0]               curve_mode,
  input  logic                     closed_loop,
  input  logic [SUB_W-1:0]         subdivisions,
  input  logic                     differ,
  output cmd_t                     cmd,
  output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] addr,
  output logic                     done,
  output logic                     no_points,
  output logic                     final_sample
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PW = $clog2(MAX_POINTS + 1);

  state_t state, state_next;

  logic [PW-1:0]    total;
  logic [PW-1:0]    seg;
  logic [SUB_W-1:0] smp;
  logic [4:0]       cnt;
  logic [1:0]       coord;
  logic             no_pts;
  logic             fin;

  logic             accept;
  logic             full;
  logic [SUB_W-1:0] sdiv;
  logic [1:0]       mode;
  logic             line;
  logic [PW:0]      n_w;
  logic [PW:0]      seg_w;
  logic [PW:0]      sel;
  logic [PW:0]      off;
  logic [PW:0]      idx;
  logic [PW:0]      len;
  logic [PW:0]      segs;
  logic             fin_now;
  logic             to_out;

  assign accept = start && (state == ST_IDLE);
  assign full   = (total == PW'(MAX_POINTS));
  assign sdiv   = (subdivisions == '0) ? SUB_W'(1) : subdivisions;
  assign n_w    = {1'b0, total};
  assign seg_w  = {1'b0, seg};

  always_comb begin
    if (total == PW'(1)) begin
      mode = MODE_POLY;
    end else if (curve_mode == MODE_POLY || curve_mode == MODE_LINE) begin
      mode = curve_mode;
    end else begin
      mode = MODE_SPLINE;
    end
  end
  assign line = (mode == MODE_LINE);

  // store address for read slot cnt[1:0]
  always_comb begin
    off = '0;
    idx = '0;
    sel = '0;
    if (mode != MODE_SPLINE) begin
      case (cnt[1:0])
        2'd0:    sel = '0;
        2'd1:    sel = n_w - 1'b1;
        2'd2:    sel = (seg_w == n_w) ? '0 : seg_w;
        default: sel = '0;
      endcase
    end else begin
      off = seg_w + {{(PW-1){1'b0}}, cnt[1:0]};
      idx = off - 1'b1;
      if (off == '0) begin
        sel = closed_loop ? (n_w - 1'b1) : '0;
      end else if (idx >= n_w) begin
        sel = closed_loop ? (idx - n_w) : (n_w - 1'b1);
      end else begin
        sel = idx;
      end
    end
  end

  assign len  = n_w + {{PW{1'b0}}, closed_loop & differ};
  assign segs = closed_loop ? n_w : (n_w - 1'b1);

  always_comb begin
    case (mode)
      MODE_POLY: fin_now = (seg_w + 1'b1) >= len;
      MODE_LINE: fin_now = smp >= sdiv;
      default:   fin_now = ((seg_w + 1'b1) >= segs) && (smp >= sdiv);
    endcase
  end

  assign to_out = (state == ST_PASS) || (state == ST_FINISH && coord == 2'd2);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode != OPC_LOAD) begin
          if (total == '0) begin
            state_next = ST_OUT;
          end else if (mode == MODE_POLY) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV:    if (cnt == 5'(DIV_W - 1)) state_next = ST_READ;
      ST_READ: begin
        if (cnt == 5'd4) begin
          if (mode == MODE_POLY) begin
            state_next = ST_PASS;
          end else if (line) begin
            state_next = ST_COEF;
          end else begin
            state_next = ST_T2;
          end
        end
      end
      ST_T2:     state_next = ST_T3;
      ST_T3:     state_next = ST_COEF;
      ST_COEF:   state_next = ST_MUL1;
      ST_MUL1:   state_next = line ? ST_FINISH : ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_FINISH;
      ST_FINISH: state_next = (coord == 2'd2) ? ST_OUT : ST_COEF;
      ST_PASS:   state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.coord   = coord;
    cmd.line    = line;
    cmd.sample  = smp;
    cmd.divisor = sdiv;
    addr        = sel[AW-1:0];
    case (state)
      ST_IDLE: begin
        addr = total[AW-1:0];
        if (accept && opcode == OPC_LOAD && !full) begin
          cmd.op = OP_LOAD;
        end else if (accept && opcode != OPC_LOAD) begin
          cmd.op = OP_DIV_INIT;
        end
      end
      ST_DIV: cmd.op = OP_DIV_STEP;
      ST_READ: begin
        cmd.op    = OP_READ;
        cmd.latch = (cnt != '0);
        cmd.slot  = 2'(cnt[2:0] - 3'd1);
      end
      ST_T2:     cmd.op = OP_T2;
      ST_T3:     cmd.op = OP_T3;
      ST_COEF:   cmd.op = OP_COEF;
      ST_MUL1:   cmd.op = OP_MUL1;
      ST_MUL2:   cmd.op = OP_MUL2;
      ST_MUL3:   cmd.op = OP_MUL3;
      ST_FINISH: cmd.op = OP_FIN;
      ST_PASS:   cmd.op = OP_PASS;
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign busy         = (state != ST_IDLE);
  assign done         = (state == ST_OUT);
  assign no_points    = no_pts;
  assign final_sample = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      total  <= '0;
      seg    <= '0;
      smp    <= '0;
      cnt    <= '0;
      coord  <= '0;
      no_pts <= 1'b0;
      fin    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + 5'd1;
      if (cfg_clear) begin
        seg <= '0;
        smp <= '0;
      end
      if (accept) begin
        coord  <= '0;
        no_pts <= (total == '0) && (opcode != OPC_LOAD);
        fin    <= 1'b0;
        if (opcode == OPC_LOAD) begin
          if (!full) total <= total + 1'b1;
          seg <= '0;
          smp <= '0;
        end
      end
      if (state == ST_FINISH) coord <= coord + 2'd1;
      if (to_out) begin
        fin <= fin_now;
        if (fin_now) begin
          seg <= '0;
          smp <= '0;
        end else begin
          case (mode)
            MODE_POLY: seg <= seg + 1'b1;
            MODE_LINE: smp <= smp + 1'b1;
            default: begin
              if (smp < sdiv) begin
                smp <= smp + 1'b1;
              end else begin
                seg <= seg + 1'b1;
                smp <= SUB_W'(1);
              end
            end
          endcase
        end
      end
    end
  end

endmodule

// ----- rtl/sct_dpath.sv -----
// Datapath for the spline curve tessellator: point store, four-point
// window, restoring divider for t, shared multiplier, accumulator, saturation.
// Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_dpath import sct_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                     clk,
  input  cmd_t                     cmd,
  input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] addr,
  input  item_t                    item,
  output logic                     differ,
  output logic signed [COORD_W-1:0] qx,
  output logic signed [COORD_W-1:0] qy,
  output logic signed [COORD_W-1:0] qz
);

  logic [3*COORD_W-1:0] mem [MAX_POINTS];
  logic [3*COORD_W-1:0] rdata;

  logic signed [COORD_W-1:0] pt [4][3];
  logic signed [COORD_W-1:0] q  [3];

  logic [DIV_W-1:0] num;
  logic [SUB_W-1:0] rem;
  logic [SUB_W:0]   remsh;
  logic             qbit;
  logic [T_W-1:0]   t;
  logic [T_W-1:0]   t2;
  logic [T_W-1:0]   t3;

  logic signed [COEF_W-1:0] a1, a2, a3;
  logic signed [ACC_W-1:0]  acc;

  logic signed [COEF_W-1:0] p0, p1, p2, p3;
  logic signed [COEF_W-1:0] ma;
  logic signed [T_W:0]      mb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  fv;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) mem[addr] <= {item.px, item.py, item.pz};
    rdata <= mem[addr];
  end

  // restoring division, one quotient bit per cycle
  assign remsh = {rem, num[DIV_W-1]};
  assign qbit  = remsh >= {1'b0, cmd.divisor};

  assign p0 = COEF_W'(pt[0][cmd.coord]);
  assign p1 = COEF_W'(pt[1][cmd.coord]);
  assign p2 = COEF_W'(pt[2][cmd.coord]);
  assign p3 = COEF_W'(pt[3][cmd.coord]);

  always_comb begin
    case (cmd.op)
      OP_T2:   begin ma = COEF_W'($signed({1'b0, t}));  mb = $signed({1'b0, t});  end
      OP_T3:   begin ma = COEF_W'($signed({1'b0, t2})); mb = $signed({1'b0, t});  end
      OP_MUL1: begin ma = a1;                            mb = $signed({1'b0, t});  end
      OP_MUL2: begin ma = a2;                            mb = $signed({1'b0, t2}); end
      OP_MUL3: begin ma = a3;                            mb = $signed({1'b0, t3}); end
      default: begin ma = '0;                            mb = '0;                  end
    endcase
  end

  assign prod = PROD_W'(ma) * PROD_W'(mb);
  assign rnd  = (prod + PROD_W'(32768)) >>> 16;
  assign term = rnd[ACC_W-1:0];
  assign fv   = cmd.line ? acc : ((acc + ACC_W'(1)) >>> 1);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIV_INIT: begin
        num <= {cmd.sample, 16'b0} + DIV_W'(cmd.divisor >> 1);
        rem <= '0;
        t   <= '0;
      end
      OP_DIV_STEP: begin
        num <= num << 1;
        rem <= qbit ? SUB_W'(remsh - {1'b0, cmd.divisor}) : remsh[SUB_W-1:0];
        t   <= {t[T_W-2:0], qbit};
      end
      OP_READ: begin
        if (cmd.latch) begin
          pt[cmd.slot][0] <= rdata[3*COORD_W-1:2*COORD_W];
          pt[cmd.slot][1] <= rdata[2*COORD_W-1:COORD_W];
          pt[cmd.slot][2] <= rdata[COORD_W-1:0];
        end
      end
      OP_T2: t2 <= rnd[T_W-1:0];
      OP_T3: t3 <= rnd[T_W-1:0];
      OP_COEF: begin
        if (cmd.line) begin
          a1  <= p1 - p0;
          acc <= ACC_W'(p0);
        end else begin
          a1  <= p2 - p0;
          a2  <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
          a3  <= p1 + (p1 <<< 1) - p0 - p2 - (p2 <<< 1) + p3;
          acc <= ACC_W'(p1) <<< 1;
        end
      end
      OP_MUL1, OP_MUL2, OP_MUL3: acc <= acc + term;
      OP_FIN:  q[cmd.coord] <= sat_coord(fv);
      OP_PASS: begin
        q[0] <= pt[2][0];
        q[1] <= pt[2][1];
        q[2] <= pt[2][2];
      end
      default: ;
    endcase
  end

  // first and last stored points, for the closed polyline
  assign differ = (pt[0][0] != pt[1][0]) || (pt[0][1] != pt[1][1]) ||
                  (pt[0][2] != pt[1][2]);

  assign qx = q[0];
  assign qy = q[1];
  assign qz = q[2];

endmodule

// ----- rtl/spline_curve_tessellator.sv -----
// Top level of the spline curve tessellator: configuration registers,
// controller and datapath. Depends on sct_pkg, sct_ctrl, sct_dpath.
`timescale 1ns / 1ps

// Usage:
//  Items enter on item with start; a transfer happens when start is high and
//  busy is low. opcode load stores (px, py, pz); busy stays low and no result
//  follows. Loads past MAX_POINTS are dropped.
//  opcode produce returns one result on result, marked by done for one cycle.
//  A result comes soonest for an empty store (no_points), then for a
//  pass-through or single point, then for a straight line, last for a spline.
//  The divider for t, the single store read port (four reads) and the one
//  shared multiplier (11 products per spline sample) set the latency. busy is
//  high until done has been shown, so the next transfer is taken in the cycle
//  after done at the earliest: a produce is not taken before the last result
//  is out, while loads can follow each other every cycle.
//  Registers (APB, byte addresses 0, 4, 8): curve_mode, closed_loop,
//  subdivisions; write them only while busy is low. A write or a load
//  restarts the curve from its first sample.
//  Reset presets the registers, clears point count and curve position; the
//  store needs no clearing. The receiver cannot stall: take result when done.
module spline_curve_tessellator import sct_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [1:0]       curve_mode;
  logic             closed_loop;
  logic [SUB_W-1:0] subdivisions;
  logic             wr;
  logic             cfg_clear;

  cmd_t             cmd;
  logic [AW-1:0]    addr;
  logic             differ;
  logic             no_points;
  logic             final_sample;
  logic signed [COORD_W-1:0] qx, qy, qz;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_clear = wr && (paddr[3:2] == REG_MODE || paddr[3:2] == REG_CLOSED ||
                            paddr[3:2] == REG_SUBDIV);

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode   <= MODE_SPLINE;
      closed_loop  <= 1'b0;
      subdivisions <= SUB_W'(1);
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODE:   curve_mode   <= pwdata[1:0];
        REG_CLOSED: closed_loop  <= pwdata[0];
        REG_SUBDIV: subdivisions <= pwdata[SUB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {30'b0, curve_mode};
      REG_CLOSED: prdata = {31'b0, closed_loop};
      REG_SUBDIV: prdata = {{(32-SUB_W){1'b0}}, subdivisions};
      default:    prdata = '0;
    endcase
  end

  sct_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (item.opcode),
    .busy         (busy),
    .cfg_clear    (cfg_clear),
    .curve_mode   (curve_mode),
    .closed_loop  (closed_loop),
    .subdivisions (subdivisions),
    .differ       (differ),
    .cmd          (cmd),
    .addr         (addr),
    .done         (done),
    .no_points    (no_points),
    .final_sample (final_sample)
  );

  sct_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
    .clk    (clk),
    .cmd    (cmd),
    .addr   (addr),
    .item   (item),
    .differ (differ),
    .qx     (qx),
    .qy     (qy),
    .qz     (qz)
  );

  // empty store answers with a zero point
  always_comb begin
    result.qx           = no_points ? '0 : qx;
    result.qy           = no_points ? '0 : qy;
    result.qz           = no_points ? '0 : qz;
    result.no_points    = no_points;
    result.final_sample = final_sample;
  end

endmodule

// ----- tb/spline_curve_tessellator_tb.sv -----
// Self-checking testbench for spline_curve_tessellator: random and directed
// point loads and sample requests, checked against an in-bench curve predictor.
// Depends on sct_pkg and the spline_curve_tessellator RTL.
`timescale 1ns / 1ps

module spline_curve_tessellator_tb;
  import sct_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        done;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  spline_curve_tessellator dut (.*);

  always #2 clk = ~clk;

  // curve predictor state
  longint pts [STORE_DEPTH][3];
  int     pt_count = 0;
  int     seg_pos = 0;
  int     smp_pos = 0;
  bit     in_run = 0;
  int     cur_mode = 0;
  int     cur_closed = 0;
  int     cur_subdiv = 1;

  item_t   pending_items[$];
  result_t expected_samples[$];
  int      gap_pct = 0;
  bit      hold = 0;
  int      mismatches = 0;
  bit      failed = 0;

  function automatic void queue_item(item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void expect_sample(result_t r);
    expected_samples.insert(expected_samples.size(), r);
  endfunction

  function automatic longint mul_t(longint c, longint t);
    longint hi, lo;
    hi = c >>> 16;
    lo = c - hi * 65536;
    return hi * t + ((lo * t + 32768) >>> 16);
  endfunction

  function automatic longint clamp(longint v);
    return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
  endfunction

  function automatic int nbr(int idx, int n, int closed);
    if (closed == 0) return idx < 0 ? 0 : (idx > n - 1 ? n - 1 : idx);
    idx = idx % n;
    return idx < 0 ? idx + n : idx;
  endfunction

  function automatic void restart_curve();
    in_run = 0;
    seg_pos = 0;
    smp_pos = 0;
  endfunction

  function automatic void predict_sample(item_t it);
    result_t r;
    longint q[3];
    longint t, t2, t3, p0, p1, p2, p3, a1, a2, a3, acc;
    int n, s_div, md, len, segs, i0, i1, i2, i3;
    bit fin;
    if (it.opcode == OPC_LOAD) begin
      if (pt_count < STORE_DEPTH) begin
        pts[pt_count][0] = it.px;
        pts[pt_count][1] = it.py;
        pts[pt_count][2] = it.pz;
        pt_count++;
      end
      restart_curve();
      return;
    end
    r = '0;
    n = pt_count;
    fin = 0;
    if (n == 0) begin
      r.no_points = 1'b1;
      expect_sample(r);
      return;
    end
    if (!in_run) begin
      in_run = 1;
      seg_pos = 0;
      smp_pos = 0;
    end
    s_div = cur_subdiv == 0 ? 1 : cur_subdiv;
    md = cur_mode == 3 ? 0 : cur_mode;
    if (n == 1) begin
      for (int k = 0; k < 3; k++) q[k] = pts[0][k];
      fin = 1;
    end else if (md == MODE_POLY) begin
      len = n;
      if (cur_closed != 0 && (pts[0][0] != pts[n-1][0] || pts[0][1] != pts[n-1][1] ||
                              pts[0][2] != pts[n-1][2]))
        len = n + 1;
      for (int k = 0; k < 3; k++) q[k] = pts[seg_pos % n][k];
      fin = seg_pos + 1 >= len;
      seg_pos++;
    end else begin
      t = (longint'(smp_pos) * 65536 + s_div / 2) / s_div;
      if (md == MODE_LINE) begin
        for (int k = 0; k < 3; k++)
          q[k] = clamp(pts[0][k] + mul_t(pts[n-1][k] - pts[0][k], t));
        fin = smp_pos >= s_div;
        smp_pos++;
      end else begin
        segs = cur_closed != 0 ? n : n - 1;
        i0 = nbr(seg_pos - 1, n, cur_closed);
        i1 = nbr(seg_pos, n, cur_closed);
        i2 = nbr(seg_pos + 1, n, cur_closed);
        i3 = nbr(seg_pos + 2, n, cur_closed);
        t2 = (t * t + 32768) >>> 16;
        t3 = (t2 * t + 32768) >>> 16;
        for (int k = 0; k < 3; k++) begin
          p0 = pts[i0][k];
          p1 = pts[i1][k];
          p2 = pts[i2][k];
          p3 = pts[i3][k];
          a1 = p2 - p0;
          a2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
          a3 = -p0 + 3 * p1 - 3 * p2 + p3;
          acc = 2 * p1 + mul_t(a1, t) + mul_t(a2, t2) + mul_t(a3, t3);
          q[k] = clamp((acc + 1) >>> 1);
        end
        fin = seg_pos + 1 >= segs && smp_pos >= s_div;
        if (smp_pos < s_div) begin
          smp_pos++;
        end else begin
          seg_pos++;
          smp_pos = 1;
        end
      end
    end
    r.qx = q[0][31:0];
    r.qy = q[1][31:0];
    r.qz = q[2][31:0];
    r.final_sample = fin;
    if (fin) restart_curve();
    expect_sample(r);
  endfunction

  // driver: item holds while start is high and busy stalls the transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) predict_sample(item);
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_items.size() > 0 && !hold && $urandom_range(99) >= gap_pct) begin
        item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_samples.size() == 0) begin
        failed = 1;
        $display("unexpected sample %h", result);
      end else begin
        want = expected_samples.pop_front();
        if (want !== result) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10)
            $display({"sample mismatch: exp x=%h y=%h z=%h np=%b fin=%b",
                      " got x=%h y=%h z=%h np=%b fin=%b"},
                     want.qx, want.qy, want.qz, want.no_points, want.final_sample,
                     result.qx, result.qy, result.qz, result.no_points,
                     result.final_sample);
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = val & 3;
      REG_CLOSED: cur_closed = val & 1;
      default:    cur_subdiv = val & 8'hff;
    endcase
    restart_curve();
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_items.size() > 0 || start || busy || expected_samples.size() > 0)
      @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_curve(int md, int cl, int sd);
    reg_write(REG_MODE, md);
    reg_write(REG_CLOSED, cl);
    reg_write(REG_SUBDIV, sd);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      2: case ($urandom_range(3))
           0: return 32'h7fffffff;
           1: return 32'h80000000;
           2: return 32'h0;
           default: return 32'hffffffff;
         endcase
      default: return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic item_t load_item(bit copy_first);
    item_t it;
    it.opcode = OPC_LOAD;
    if (copy_first && pt_count > 0) begin
      it.px = pts[0][0][31:0];
      it.py = pts[0][1][31:0];
      it.pz = pts[0][2][31:0];
    end else begin
      it.px = rand_coord();
      it.py = rand_coord();
      it.pz = rand_coord();
    end
    return it;
  endfunction

  function automatic item_t produce_item();
    item_t it;
    it = load_item(0);  // coordinates are ignored on produce
    it.opcode = ~OPC_LOAD;
    return it;
  endfunction

  task automatic push_items(int nloads, int nprod, bit copy_first);
    @(negedge clk);
    for (int i = 0; i < nloads; i++) queue_item(load_item(copy_first));
    for (int i = 0; i < nprod; i++) queue_item(produce_item());
  endtask

  initial begin
    item_t it;
    int md, sd, nprod;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: empty store, single point, extremes, every mode
    push_items(0, 2, 0);
    drain();
    @(negedge clk);
    it = '0;
    it.px = 32'h7fffffff;
    it.py = 32'h80000000;
    it.pz = 32'hffffffff;
    queue_item(it);
    queue_item(produce_item());
    queue_item(produce_item());
    it.px = 32'h80000000;
    it.py = 32'h7fffffff;
    it.pz = 32'h00000000;
    queue_item(it);
    for (int i = 0; i < 3; i++) queue_item(produce_item());
    drain();
    set_curve(MODE_LINE, 0, 255);
    push_items(0, 3, 0);
    drain();
    set_curve(MODE_POLY, 1, 0);
    push_items(0, 4, 0);
    drain();
    set_curve(3, 1, 2);
    push_items(1, 6, 0);
    drain();
    set_curve(MODE_POLY, 1, 1);
    push_items(1, 5, 1);
    drain();
    // random phases: sender gap 9%, then 65%, then none
    for (int ph = 0; ph < 30; ph++) begin
      gap_pct = ph < 10 ? 9 : (ph < 20 ? 65 : 0);
      md = $urandom_range(3);
      sd = $urandom_range(9) == 0 ? ($urandom_range(1) ? 255 : 0) : $urandom_range(1, 5);
      set_curve(md, $urandom_range(1), sd);
      nprod = (sd == 255 && md != MODE_POLY) ? 8 : $urandom_range(25, 40);
      push_items(ph == 29 ? 70 : $urandom_range(0, 2), nprod / 2, $urandom_range(3) == 0);
      if (ph == 5) begin
        @(negedge clk);
        hold <= 1'b1;
        @(negedge clk);
        while (start || busy || expected_samples.size() > 0) @(negedge clk);
        hold <= 1'b0;
      end
      push_items($urandom_range(2) == 0, nprod - nprod / 2, 0);
      drain();
    end
    if (!failed && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
